// ===== hw/rtl/imt_pkg.sv =====
// shared types, constants and microcode codes for the interval timer moving average
package imt_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int TS_W          = 64;
  localparam int DUR_W         = 32;
  localparam int WIN_W         = 8;
  localparam int SUM_W         = DUR_W + WIN_W;
  localparam int FRAC_W        = 8;
  localparam int DVD_W         = SUM_W + FRAC_W;
  localparam int AVG_W         = 40;
  localparam int HELD_W        = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;
  localparam int DIV_CNT_W     = $clog2(DVD_W + 1);
  localparam int PC_W          = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_REARM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(1);

  typedef struct packed {
    logic            action;
    logic [TS_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic              avg_valid;
    logic [AVG_W-1:0]  avg_duration_q8;
    logic [HELD_W-1:0] samples_held;
  } out_item_t;

  // input actions
  localparam logic ACT_MARK   = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_WAIT    = 4'd0,
    OP_UPDATE  = 4'd1,
    OP_SETUP   = 4'd2,
    OP_LOAD    = 4'd3,
    OP_ACC     = 4'd4,
    OP_DIVINIT = 4'd5,
    OP_DIV     = 4'd6,
    OP_EMIT    = 4'd7,
    OP_NOP     = 4'd8
  } op_t;

  // jump condition of one microcode step
  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_ALWAYS      = 3'd1,
    COND_NO_INPUT    = 3'd2,
    COND_SHORT       = 3'd3,
    COND_MORE        = 3'd4,
    COND_DIV_MORE    = 3'd5,
    COND_OUT_BLOCKED = 3'd6
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // datapath flags the sequencer branches on
  typedef struct packed {
    logic in_fire;
    logic short_window;
    logic more_reads;
    logic div_more;
    logic out_blocked;
  } status_t;

endpackage

// ===== hw/rtl/interval_timer_moving_average_top.sv =====
// top level: interval timer with a moving average over a ring of recorded durations
// Each transfer on the input channel either marks the reference time (action 0) or
// records the microseconds elapsed since the reference (action 1), saturated to 32
// bits, into a ring of DEPTH entries; with auto_rearm set, a record also moves the
// reference to its timestamp. Every input transfer yields exactly one output transfer
// carrying samples_held, and, once at least window_len durations exist, the mean of
// the most recent window_len of them in unsigned Q32.8 (truncated); before that the
// mean reads 0 with avg_valid low. The ring has one read port, so the sum reads one
// entry a cycle, and the mean comes from a restoring divider that retires one
// quotient bit a cycle over 48 bits; without a valid mean both steps are skipped.
// One item is in flight at a time; the finished result sits in an output register,
// so the next item is taken while that result waits. Neither input nor configuration
// is ready during reset. Configuration writes are otherwise always ready and belong
// in idle time; a window_len write of 0 or above DEPTH is dropped. The ring itself
// has no reset and needs no clearing pass.
module interval_timer_moving_average_top #(
  parameter int DEPTH = imt_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // item input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  imt_pkg::in_item_t                  in_item,
  // result output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output imt_pkg::out_item_t                 out_item,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import imt_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int HW        = (CW > WIN_W) ? CW : WIN_W;
  localparam int WIN_RESET = (DEPTH < 128) ? DEPTH : 128;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // sequencer interface
  ucode_t  uword;
  status_t status;

  // configuration registers
  logic             auto_rearm;
  logic [WIN_W-1:0] window_len;

  // timer state
  logic [TS_W-1:0] ref_time;
  logic [AW-1:0]   write_slot;
  logic            ring_filled;

  // latched input item
  logic            act;
  logic [TS_W-1:0] ts;

  // ring memory, one write and one registered read per cycle
  logic [DUR_W-1:0] ring [DEPTH];
  logic [DUR_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic             ring_we;

  // summation and division datapath
  logic [AW-1:0]        idx;
  logic [WIN_W-1:0]     reads;
  logic [SUM_W-1:0]     sum;
  logic [DVD_W-1:0]     dvd;
  logic [WIN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [HW-1:0]        held;
  logic                 mean_ok;

  logic [TS_W-1:0]  elapsed;
  logic [DUR_W-1:0] dur;
  logic [CW-1:0]    held_now;
  logic [WIN_W:0]   rem_shift;
  logic [WIN_W:0]   rem_diff;
  logic             q_bit;
  logic             emit;

  imt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  // handshakes
  assign in_ready  = (uword.op == OP_WAIT) && !rst;
  assign cfg_ready = !rst;
  assign emit      = (uword.op == OP_EMIT) && !status.out_blocked;

  // duration since the reference, modulo 2^64, clamped to 32 bits
  assign elapsed = ts - ref_time;
  assign dur     = (|elapsed[TS_W-1:DUR_W]) ? '1 : elapsed[DUR_W-1:0];
  assign ring_we = (uword.op == OP_UPDATE) && (act == ACT_RECORD);

  assign held_now = ring_filled ? CW'(DEPTH) : CW'(write_slot);

  // walk backward from the newest entry
  assign rd_addr = (idx == '0) ? LAST_SLOT : idx - AW'(1);
  assign rd_en   = (uword.op == OP_LOAD) || ((uword.op == OP_ACC) && status.more_reads);

  // one restoring divide step per cycle
  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, window_len};
  assign q_bit     = (rem_shift >= {1'b0, window_len});

  // branch flags
  assign status.in_fire      = in_valid && in_ready;
  assign status.short_window = (HW'(held_now) < HW'(window_len));
  assign status.more_reads   = (reads < window_len);
  assign status.div_more     = (div_cnt > DIV_CNT_W'(1));
  assign status.out_blocked  = out_valid && !out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_rearm <= 1'b1;
      window_len <= WIN_W'(WIN_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AUTO_REARM: auto_rearm <= cfg_data[0];
        REG_WINDOW_LEN: begin
          if ((cfg_data != '0) && (int'(cfg_data) <= DEPTH)) begin
            window_len <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_slot] <= dur;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  // timer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_time    <= '0;
      write_slot  <= '0;
      ring_filled <= 1'b0;
    end else if (uword.op == OP_UPDATE) begin
      if (act == ACT_MARK) begin
        ref_time <= ts;
      end else begin
        if (auto_rearm) begin
          ref_time <= ts;
        end
        if (write_slot == LAST_SLOT) begin
          write_slot  <= '0;
          ring_filled <= 1'b1;
        end else begin
          write_slot <= write_slot + AW'(1);
        end
      end
    end
  end

  // item latch, sum and divider, no reset needed
  always_ff @(posedge clk) begin
    if (status.in_fire) begin
      act <= in_item.action;
      ts  <= in_item.timestamp_us;
    end
    case (uword.op)
      OP_SETUP: begin
        held    <= HW'(held_now);
        mean_ok <= !status.short_window;
        sum     <= '0;
        idx     <= write_slot;
        reads   <= '0;
      end
      OP_LOAD: begin
        idx   <= rd_addr;
        reads <= WIN_W'(1);
      end
      OP_ACC: begin
        sum <= sum + SUM_W'(rd_data);
        if (status.more_reads) begin
          idx   <= rd_addr;
          reads <= reads + WIN_W'(1);
        end
      end
      OP_DIVINIT: begin
        dvd     <= {sum, FRAC_W'(0)};
        rem     <= '0;
        div_cnt <= DIV_CNT_W'(DVD_W);
      end
      OP_DIV: begin
        dvd     <= {dvd[DVD_W-2:0], q_bit};
        rem     <= q_bit ? rem_diff[WIN_W-1:0] : rem_shift[WIN_W-1:0];
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.avg_valid       <= mean_ok;
      out_item.avg_duration_q8 <= mean_ok ? dvd[AVG_W-1:0] : '0;
      out_item.samples_held    <= held[HELD_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/imt_seq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
module imt_seq (
  input  logic             clk,
  input  logic             rst,
  input  imt_pkg::status_t status,
  output imt_pkg::ucode_t  uword
);
  import imt_pkg::*;

  localparam pc_t STEP_WAIT = pc_t'(0);
  localparam pc_t STEP_ACC  = pc_t'(4);
  localparam pc_t STEP_DIV  = pc_t'(6);
  localparam pc_t STEP_EMIT = pc_t'(7);

  pc_t  pc;
  pc_t  pc_next;
  logic take;

  // control store
  function automatic ucode_t rom_word(pc_t addr);
    ucode_t w;
    unique case (addr)
      pc_t'(0): w = '{op: OP_WAIT,    cond: COND_NO_INPUT,    target: STEP_WAIT};
      pc_t'(1): w = '{op: OP_UPDATE,  cond: COND_NEVER,       target: STEP_WAIT};
      pc_t'(2): w = '{op: OP_SETUP,   cond: COND_SHORT,       target: STEP_EMIT};
      pc_t'(3): w = '{op: OP_LOAD,    cond: COND_NEVER,       target: STEP_WAIT};
      pc_t'(4): w = '{op: OP_ACC,     cond: COND_MORE,        target: STEP_ACC};
      pc_t'(5): w = '{op: OP_DIVINIT, cond: COND_NEVER,       target: STEP_WAIT};
      pc_t'(6): w = '{op: OP_DIV,     cond: COND_DIV_MORE,    target: STEP_DIV};
      pc_t'(7): w = '{op: OP_EMIT,    cond: COND_OUT_BLOCKED, target: STEP_EMIT};
      pc_t'(8): w = '{op: OP_NOP,     cond: COND_ALWAYS,      target: STEP_WAIT};
      default:  w = '{op: OP_NOP,     cond: COND_ALWAYS,      target: STEP_WAIT};
    endcase
    return w;
  endfunction

  assign uword = rom_word(pc);

  always_comb begin
    unique case (uword.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = !status.in_fire;
      COND_SHORT:       take = status.short_window;
      COND_MORE:        take = status.more_reads;
      COND_DIV_MORE:    take = status.div_more;
      COND_OUT_BLOCKED: take = status.out_blocked;
      default:          take = 1'b1;
    endcase
    pc_next = take ? uword.target : pc + pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
